// ----- rtl/sorted_key_table_lookup_unit_defines.svh -----
// Assertion macros used by the port-level checker of the lookup unit.
`ifndef SORTED_KEY_TABLE_LOOKUP_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKTL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sktl_pkg.sv -----
// ----------------------------------------------------------------------------
// sktl_pkg
// Shared types and constants of the sorted key table lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sktl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int KEY_W     = 32;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_USED = 1'b1;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Table codes
    localparam logic TBL_ZONE = 1'b0;
    localparam logic TBL_RULE = 1'b1;

    localparam logic signed [WORD_W-1:0] MISS_WORD = -32'sd1;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [WORD_W-1:0] first;
        logic signed [WORD_W-1:0] count;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_key_table_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_unit
// Two sorted key tables (zone, rule) with a binary search lookup.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ---------------------------------------------
//  request   start && !busy         req_type, table_select, entry_index,
//                                   search_key, first_value, count_value
//  result    done (1-cycle strobe)  hit, result_key, result_first, result_count
//  config    cfg_write              cfg_index, cfg_wdata
//
//  Sequencing: a write, or a lookup on an empty table, strobes done in the
//  cycle after the accepting edge and busy never rises. A lookup over N used
//  entries runs one probe per cycle, at most floor(log2(N))+1 probes, and
//  strobes done in the cycle after the last probe. The probe rate is set by the
//  single registered read port of each table, which serves one probe per cycle.
//  Reset clears the sequencer, the result strobe and both used-entry counts;
//  table contents are undefined until written. The receiver cannot stall:
//  each result beat stands for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_lookup_unit #(
    parameter int TABLE_DEPTH = sktl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request beat
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic                                table_select,
    input  logic [sktl_pkg::IDX_W-1:0]          entry_index,
    input  logic [sktl_pkg::KEY_W-1:0]          search_key,
    input  logic signed [sktl_pkg::WORD_W-1:0]  first_value,
    input  logic signed [sktl_pkg::WORD_W-1:0]  count_value,
    // result beat
    output logic                                done,
    output logic                                hit,
    output logic [sktl_pkg::KEY_W-1:0]          result_key,
    output logic signed [sktl_pkg::WORD_W-1:0]  result_first,
    output logic signed [sktl_pkg::WORD_W-1:0]  result_count,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [sktl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sktl_pkg::CFG_W-1:0]          cfg_wdata
);
    import sktl_pkg::*;

    // Table address width and width of a bound that can reach the depth itself.
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    // ------------------------------------------------------------------
    // Control and search registers
    // ------------------------------------------------------------------
    logic               state_reg, state_next;
    logic [CFG_W-1:0]   zone_used_reg, zone_used_next;
    logic [CFG_W-1:0]   rule_used_reg, rule_used_next;
    logic               done_reg, done_next;

    logic [KEY_W-1:0]   key_reg, key_next;
    logic               sel_reg, sel_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      mid_reg, mid_next;

    logic               hit_reg, hit_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    logic signed [WORD_W-1:0] res_first_reg, res_first_next;
    logic signed [WORD_W-1:0] res_count_reg, res_count_next;

    // ------------------------------------------------------------------
    // Table storage: one array per table, one write and one read a cycle
    // ------------------------------------------------------------------
    entry_t zone_mem [TABLE_DEPTH];
    entry_t rule_mem [TABLE_DEPTH];
    entry_t zone_rd_reg;
    entry_t rule_rd_reg;

    logic               accept;
    logic [CFG_W-1:0]   used_sel;
    logic [31:0]        used_clamp32;
    logic [CW-1:0]      used_clamp;
    logic [31:0]        idx32;
    logic               idx_in_range;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_entry;
    logic               zone_we;
    logic               rule_we;

    entry_t             probe;
    logic               key_eq;
    logic               key_gt;

    // shared midpoint unit
    logic [CW-1:0]      seed_lo;
    logic [CW-1:0]      seed_hi;
    logic               seed_open;
    logic [SW-1:0]      mid_sum;
    logic [CW-1:0]      mid_half;
    logic [AW-1:0]      mid_calc;
    logic               rd_en;

    assign accept = start && (state_reg == ST_IDLE);

    // Used count of the requested table, saturated at the table depth.
    assign used_sel     = (table_select == TBL_RULE) ? rule_used_reg : zone_used_reg;
    assign used_clamp32 = (32'(used_sel) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                             : 32'(used_sel);
    assign used_clamp   = used_clamp32[CW-1:0];

    // Drop writes to slots beyond the table.
    assign idx32        = 32'(entry_index);
    assign idx_in_range = idx32 < 32'(TABLE_DEPTH);
    assign wr_addr      = idx32[AW-1:0];
    assign wr_entry     = '{key: search_key, first: first_value, count: count_value};
    assign zone_we      = accept && (req_type == REQ_WRITE) && idx_in_range
                          && (table_select == TBL_ZONE);
    assign rule_we      = accept && (req_type == REQ_WRITE) && idx_in_range
                          && (table_select == TBL_RULE);

    // Probe result of the previous cycle's read.
    assign probe  = (sel_reg == TBL_RULE) ? rule_rd_reg : zone_rd_reg;
    assign key_eq = probe.key == key_reg;
    assign key_gt = key_reg > probe.key;

    // Bounds are kept as [lo, hi): the interval is open while lo < hi and
    // the probe sits at floor((lo + hi - 1) / 2).
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            seed_lo = '0;
            seed_hi = used_clamp;
        end
        else if (key_gt)
        begin
            seed_lo = CW'(mid_reg) + CW'(1);
            seed_hi = hi_reg;
        end
        else
        begin
            seed_lo = lo_reg;
            seed_hi = CW'(mid_reg);
        end
    end

    assign seed_open = seed_lo < seed_hi;
    assign mid_sum   = SW'(seed_lo) + SW'(seed_hi) - SW'(1);
    assign mid_half  = mid_sum[SW-1:1];
    assign mid_calc  = mid_half[AW-1:0];

    assign rd_en = seed_open &&
                   ((accept && (req_type == REQ_LOOKUP)) ||
                    ((state_reg == ST_SEARCH) && !key_eq));

    always_ff @(posedge clk)
    begin
        if (zone_we)
        begin
            zone_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            zone_rd_reg <= zone_mem[mid_calc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rule_rd_reg <= rule_mem[mid_calc];
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_comb
    begin
        zone_used_next = zone_used_reg;
        rule_used_next = rule_used_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ZONE_USED: zone_used_next = cfg_wdata;
                REG_RULE_USED: rule_used_next = cfg_wdata;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        done_next      = 1'b0;
        key_next       = key_reg;
        sel_next       = sel_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        res_key_next   = res_key_reg;
        res_first_next = res_first_reg;
        res_count_next = res_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        // Acknowledge the write with the written beat.
                        done_next      = 1'b1;
                        hit_next       = 1'b0;
                        res_key_next   = search_key;
                        res_first_next = first_value;
                        res_count_next = count_value;
                    end
                    else if (!seed_open)
                    begin
                        // Empty table: miss at once.
                        done_next      = 1'b1;
                        hit_next       = 1'b0;
                        res_key_next   = search_key;
                        res_first_next = MISS_WORD;
                        res_count_next = MISS_WORD;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                        key_next   = search_key;
                        sel_next   = table_select;
                        lo_next    = seed_lo;
                        hi_next    = seed_hi;
                        mid_next   = mid_calc;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (key_eq)
                begin
                    state_next     = ST_IDLE;
                    done_next      = 1'b1;
                    hit_next       = 1'b1;
                    res_key_next   = key_reg;
                    res_first_next = probe.first;
                    res_count_next = probe.count;
                end
                else if (!seed_open)
                begin
                    // Interval closed without a match.
                    state_next     = ST_IDLE;
                    done_next      = 1'b1;
                    hit_next       = 1'b0;
                    res_key_next   = key_reg;
                    res_first_next = MISS_WORD;
                    res_count_next = MISS_WORD;
                end
                else
                begin
                    // Advance to the next probe.
                    lo_next  = seed_lo;
                    hi_next  = seed_hi;
                    mid_next = mid_calc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            zone_used_reg <= '0;
            rule_used_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            zone_used_reg <= zone_used_next;
            rule_used_reg <= rule_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        sel_reg       <= sel_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        hit_reg       <= hit_next;
        res_key_reg   <= res_key_next;
        res_first_reg <= res_first_next;
        res_count_reg <= res_count_next;
    end

    assign busy         = state_reg == ST_SEARCH;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign result_key   = res_key_reg;
    assign result_first = res_first_reg;
    assign result_count = res_count_reg;

endmodule

`default_nettype wire

// ----- rtl/sktl_checker.sv -----
// ----------------------------------------------------------------------------
// sktl_checker
// Port-level checks of the sorted key table lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_lookup_unit_defines.svh"

module sktl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                req_type,
    input logic [sktl_pkg::KEY_W-1:0]          search_key,
    input logic signed [sktl_pkg::WORD_W-1:0]  first_value,
    input logic signed [sktl_pkg::WORD_W-1:0]  count_value,
    input logic                                done,
    input logic                                hit,
    input logic [sktl_pkg::KEY_W-1:0]          result_key,
    input logic signed [sktl_pkg::WORD_W-1:0]  result_first,
    input logic signed [sktl_pkg::WORD_W-1:0]  result_count
);
    import sktl_pkg::*;

    // A write beat is acknowledged in the next cycle with its own payload.
    `SKTL_ASSERT_NEXT(a_write_ack, clk, rst_n, start && !busy && req_type == REQ_WRITE, done && !hit && result_key == $past(search_key) && result_first == $past(first_value) && result_count == $past(count_value), "write beat not acknowledged with its payload")

    // A lookup either starts searching or answers at once.
    `SKTL_ASSERT_NEXT(a_lookup_moves, clk, rst_n, start && !busy && req_type == REQ_LOOKUP, busy || done, "lookup beat neither searching nor answered")

    // A result beat only leaves an idle unit.
    `SKTL_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobed while still searching")

    // Every search ends with a result beat.
    `SKTL_ASSERT_SAME(a_search_ends, clk, rst_n, $fell(busy), done, "search ended without a result")

endmodule

bind sorted_key_table_lookup_unit sktl_checker u_sktl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .search_key   (search_key),
    .first_value  (first_value),
    .count_value  (count_value),
    .done         (done),
    .hit          (hit),
    .result_key   (result_key),
    .result_first (result_first),
    .result_count (result_count)
);

`default_nettype wire

// ----- sim/sorted_key_table_lookup_unit_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_unit_checker
// Watches the request, result and config channels of the lookup unit, keeps
// its own copy of both tables and the used-entry counts, predicts every
// result beat and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_unit_checker #(
    parameter int TABLE_DEPTH = sktl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                req_type,
    input  logic                                table_select,
    input  logic [sktl_pkg::IDX_W-1:0]          entry_index,
    input  logic [sktl_pkg::KEY_W-1:0]          search_key,
    input  logic signed [sktl_pkg::WORD_W-1:0]  first_value,
    input  logic signed [sktl_pkg::WORD_W-1:0]  count_value,
    input  logic                                done,
    input  logic                                hit,
    input  logic [sktl_pkg::KEY_W-1:0]          result_key,
    input  logic signed [sktl_pkg::WORD_W-1:0]  result_first,
    input  logic signed [sktl_pkg::WORD_W-1:0]  result_count,
    input  logic                                cfg_write,
    input  logic [sktl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sktl_pkg::CFG_W-1:0]          cfg_wdata,
    output int                                  fail_count,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sktl_pkg::*;

    typedef struct packed {
        logic   hit;
        entry_t ent;
    } lookup_answer_t;

    entry_t           zone_tab [TABLE_DEPTH];
    entry_t           rule_tab [TABLE_DEPTH];
    logic [CFG_W-1:0] zone_used;
    logic [CFG_W-1:0] rule_used;
    lookup_answer_t   answer_q [$];
    lookup_answer_t   want;
    entry_t           beat_entry;

    // Binary search over the used part of one table; used counts saturate.
    function automatic lookup_answer_t search_sorted(logic sel, logic [KEY_W-1:0] key);
        int             lo;
        int             hi;
        int             mid;
        int             used;
        entry_t         probe;
        lookup_answer_t ans;
        used = (sel == TBL_ZONE) ? int'(zone_used) : int'(rule_used);
        if (used > TABLE_DEPTH)
            used = TABLE_DEPTH;
        lo = 0;
        hi = used - 1;
        ans.hit       = 1'b0;
        ans.ent.key   = key;
        ans.ent.first = MISS_WORD;
        ans.ent.count = MISS_WORD;
        while (lo <= hi && !ans.hit) begin
            mid   = (lo + hi) / 2;
            probe = (sel == TBL_ZONE) ? zone_tab[mid] : rule_tab[mid];
            if (probe.key == key) begin
                ans.hit = 1'b1;
                ans.ent = probe;
            end
            else if (key > probe.key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return ans;
    endfunction

    task automatic check_field(string field, logic [KEY_W-1:0] exp_val,
                               logic [KEY_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            answer_q.delete();
            zone_used = '0;
            rule_used = '0;
            outstanding <= 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_ZONE_USED)
                    zone_used = cfg_wdata;
                else if (cfg_index == REG_RULE_USED)
                    rule_used = cfg_wdata;
            end
            // Retire the oldest expectation before taking in a new beat.
            if (done) begin
                if (answer_q.size() == 0) begin
                    $error("result beat with nothing outstanding: key 0x%08h", result_key);
                    fail_count++;
                end
                else begin
                    want = answer_q.pop_front();
                    check_field("hit", KEY_W'(want.hit), KEY_W'(hit));
                    check_field("result_key", want.ent.key, result_key);
                    check_field("result_first", want.ent.first, result_first);
                    check_field("result_count", want.ent.count, result_count);
                end
            end
            if (start && !busy) begin
                if (req_type == REQ_WRITE) begin
                    beat_entry = '{key: search_key, first: first_value, count: count_value};
                    if (int'(entry_index) < TABLE_DEPTH) begin
                        if (table_select == TBL_ZONE)
                            zone_tab[entry_index] = beat_entry;
                        else
                            rule_tab[entry_index] = beat_entry;
                    end
                    want = '{hit: 1'b0, ent: beat_entry};
                end
                else
                    want = search_sorted(table_select, search_key);
                answer_q.push_back(want);
            end
            outstanding <= answer_q.size();
        end
    end

endmodule

// ----- sim/sorted_key_table_lookup_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_unit_tb
// Drives table writes, lookups and used-count settings into the lookup unit
// and gives the verdict; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sktl_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int CFG_MAX     = (1 << CFG_W) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_BEATS = 100;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic                 req_type     = REQ_WRITE;
    logic                 table_select = TBL_ZONE;
    logic [IDX_W-1:0]     entry_index  = '0;
    logic [KEY_W-1:0]     search_key   = '0;
    logic signed [WORD_W-1:0] first_value = '0;
    logic signed [WORD_W-1:0] count_value = '0;
    logic                 cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_ZONE_USED;
    logic [CFG_W-1:0]     cfg_wdata    = '0;

    logic                 busy;
    logic                 done;
    logic                 hit;
    logic [KEY_W-1:0]     result_key;
    logic signed [WORD_W-1:0] result_first;
    logic signed [WORD_W-1:0] result_count;

    int fail_count;
    int outstanding;

    // Stimulus-side bookkeeping: which slots hold data and what keys they
    // hold, so lookups can aim at present keys and used counts never reach
    // a slot that was never written.
    logic [KEY_W-1:0] shadow_key     [2][DEPTH];
    bit               shadow_written [2][DEPTH];
    int               shadow_used    [2];

    bit idle_mode = 1'b1;
    int writes_sent;
    int lookups_sent;
    int settings_made;

    sorted_key_table_lookup_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_select (table_select),
        .entry_index  (entry_index),
        .search_key   (search_key),
        .first_value  (first_value),
        .count_value  (count_value),
        .done         (done),
        .hit          (hit),
        .result_key   (result_key),
        .result_first (result_first),
        .result_count (result_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    sorted_key_table_lookup_unit_checker #(
        .TABLE_DEPTH(DEPTH)
    ) lookup_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .table_select (table_select),
        .entry_index  (entry_index),
        .search_key   (search_key),
        .first_value  (first_value),
        .count_value  (count_value),
        .done         (done),
        .hit          (hit),
        .result_key   (result_key),
        .result_first (result_first),
        .result_count (result_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one request beat and hold it until the block takes it. Returns
    // at the accepting edge with start still high, so a following beat can
    // go out back to back without start dropping.
    task automatic send_beat(input logic req, input logic sel, input logic [IDX_W-1:0] idx,
                             input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] first,
                             input logic [WORD_W-1:0] count);
        if (idle_mode && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= req;
        table_select <= sel;
        entry_index  <= idx;
        search_key   <= key;
        first_value  <= first;
        count_value  <= count;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (req == REQ_WRITE)
            writes_sent++;
        else
            lookups_sent++;
    endtask

    task automatic put_entry(input logic sel, input int slot, input logic [KEY_W-1:0] key,
                             input logic [WORD_W-1:0] first, input logic [WORD_W-1:0] count);
        send_beat(REQ_WRITE, sel, IDX_W'(slot), key, first, count);
        shadow_key[sel][slot]     = key;
        shadow_written[sel][slot] = 1'b1;
    endtask

    // Lookup beat: slot and payload fields are don't-care, so randomize them.
    task automatic find_key(input logic sel, input logic [KEY_W-1:0] key);
        send_beat(REQ_LOOKUP, sel, IDX_W'($urandom()), key, $urandom(), $urandom());
    endtask

    // Drop start and wait until every result beat has come back. The first
    // edge lets the checker count a beat taken at the edge we return from.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_used(input logic [CFG_IDX_W-1:0] reg_idx, input int value);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= reg_idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        shadow_used[(reg_idx == REG_ZONE_USED) ? TBL_ZONE : TBL_RULE] = value;
        settings_made++;
    endtask

    // Fill slots 0..n-1 with strictly ascending keys spread over the whole
    // 32-bit range: each slot draws from its own disjoint window.
    task automatic load_sorted(input logic sel, input int n);
        longint step;
        longint key_base;
        step = 64'h1_0000_0000 / (n + 1);
        for (int slot = 0; slot < n; slot++) begin
            key_base = slot * step + $urandom_range(0, int'(step - 1));
            put_entry(sel, slot, KEY_W'(key_base), $urandom(), $urandom());
        end
    endtask

    // Mix of lookups: present keys, their neighbors, random keys and the
    // key extremes, mostly on the chosen table. Now and then slip in a
    // stray write, which may break the ascending order on purpose.
    task automatic lookup_burst(input logic sel, input int beats);
        logic             tsel;
        logic [KEY_W-1:0] key;
        int               span;
        int               pick;
        for (int i = 0; i < beats; i++) begin
            tsel = ($urandom_range(0, 4) == 0) ? ~sel : sel;
            span = (shadow_used[tsel] > DEPTH) ? DEPTH : shadow_used[tsel];
            pick = $urandom_range(0, 99);
            key  = $urandom();
            if (span > 0 && pick < 70) begin
                key = shadow_key[tsel][$urandom_range(0, span - 1)];
                if (pick >= 50)
                    key = (pick < 60) ? key + 1 : key - 1;
            end
            else if (pick >= 90)
                key = pick[0] ? '1 : '0;
            find_key(tsel, key);
            if ($urandom_range(0, 9) == 0)
                put_entry(1'($urandom_range(0, 1)), $urandom_range(0, DEPTH - 1),
                          $urandom(), $urandom(), $urandom());
        end
    endtask

    // Watchdog: stop a hung run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run stopped at the cycle limit with %0d results outstanding", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic sel;
        int   n;
        int   new_used;
        int   prefix;
        int   random_start;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty tables after reset: every lookup misses.
        find_key(TBL_ZONE, '0);
        find_key(TBL_RULE, '1);

        // Zone: extreme keys and payload words, ascending.
        put_entry(TBL_ZONE, 0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        put_entry(TBL_ZONE, 1, 32'h0000_1000, 32'hFFFF_FFFF, 32'h0000_0000);
        put_entry(TBL_ZONE, 2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        // Top slot of the rule table.
        put_entry(TBL_RULE, DEPTH - 1, 32'h5A5A_5A5A, 32'h1234_5678, 32'hEDCB_A987);
        // Rule: descending keys, so the search may miss present keys.
        put_entry(TBL_RULE, 0, 32'd400, 32'd4, 32'd40);
        put_entry(TBL_RULE, 1, 32'd300, 32'd3, 32'd30);
        put_entry(TBL_RULE, 2, 32'd200, 32'd2, 32'd20);
        put_entry(TBL_RULE, 3, 32'd100, 32'd1, 32'd10);

        write_used(REG_ZONE_USED, 3);
        write_used(REG_RULE_USED, 4);
        find_key(TBL_ZONE, 32'h0000_0000);
        find_key(TBL_ZONE, 32'h0000_1000);
        find_key(TBL_ZONE, 32'hFFFF_FFFF);
        find_key(TBL_ZONE, 32'h0000_0FFF);
        find_key(TBL_ZONE, 32'h0000_1001);
        for (int k = 1; k <= 4; k++)
            find_key(TBL_RULE, KEY_W'(k * 100));

        // Shrink the zone view: a present key beyond the used count misses.
        write_used(REG_ZONE_USED, 1);
        find_key(TBL_ZONE, 32'hFFFF_FFFF);
        find_key(TBL_ZONE, 32'h0000_0000);
        write_used(REG_ZONE_USED, 0);
        find_key(TBL_ZONE, 32'h0000_0000);

        // Fill the whole rule table, then search it at full depth and with
        // a used count past the depth, which must saturate.
        load_sorted(TBL_RULE, DEPTH);
        for (int s = 0; s < 3; s++) begin
            write_used(REG_RULE_USED, (s == 0) ? DEPTH : (s == 1) ? DEPTH + 1 : CFG_MAX);
            find_key(TBL_RULE, shadow_key[TBL_RULE][0]);
            find_key(TBL_RULE, shadow_key[TBL_RULE][DEPTH - 1]);
            lookup_burst(TBL_RULE, 12);
        end

        // Random phases: reload a table with sorted keys, set its used count,
        // then search it. Advance until enough random beats have gone out.
        random_start = writes_sent + lookups_sent;
        while (writes_sent + lookups_sent - random_start < RANDOM_BEATS) begin
            // Keep the tail of the run free of idle gaps.
            if (writes_sent + lookups_sent - random_start > RANDOM_BEATS * 85 / 100)
                idle_mode = 1'b0;
            else
                idle_mode = ($urandom_range(0, 3) != 0);
            sel = 1'($urandom_range(0, 1));
            if (sel == TBL_RULE && $urandom_range(0, 9) == 0)
                // Rule is fully written: any count up to the register max is safe.
                new_used = $urandom_range(DEPTH / 2, CFG_MAX);
            else begin
                n = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 64);
                load_sorted(sel, n);
                if (n > 1 && $urandom_range(0, 9) == 0)
                    put_entry(sel, $urandom_range(0, n - 1), $urandom(), $urandom(), $urandom());
                new_used = n;
                if ($urandom_range(0, 6) == 0) begin
                    // Any count within the written prefix, stale entries included.
                    prefix = 0;
                    while (prefix < DEPTH && shadow_written[sel][prefix])
                        prefix++;
                    new_used = $urandom_range(0, prefix);
                end
            end
            write_used((sel == TBL_ZONE) ? REG_ZONE_USED : REG_RULE_USED, new_used);
            lookup_burst(sel, $urandom_range(4, 24));
        end

        settle();
        repeat (16) @(posedge clk);

        $display("Covered %0d entry writes and %0d lookups over %0d used-count settings,",
                 writes_sent, lookups_sent, settings_made);
        $display("with empty, unsorted, partly used, full and saturated tables.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sktl_pkg.sv
rtl/sorted_key_table_lookup_unit.sv
rtl/sktl_checker.sv
sim/sorted_key_table_lookup_unit_checker.sv
sim/sorted_key_table_lookup_unit_tb.sv
